>>> design/two_level_bitmap_allocator_unit_macros.svh
// Assertion macros used by the allocator unit.
`ifndef TWO_LEVEL_BITMAP_ALLOCATOR_UNIT_MACROS_SVH
`define TWO_LEVEL_BITMAP_ALLOCATOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is high.
`define TLBA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tlba check failed: same-cycle implication");
// Next-cycle implication, disabled while reset is high.
`define TLBA_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tlba check failed: next-cycle implication");
`else
`define TLBA_ASSERT_IMP(label, clk, rst, ante, cons)
`define TLBA_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

>>> design/tlba_pkg.sv
`timescale 1ns / 1ps

package tlba_pkg;

  localparam int WORD_BITS = 64;

  typedef logic [1:0]  opcode_t;
  typedef logic [1:0]  status_t;
  typedef logic [6:0]  count_t;
  typedef logic [11:0] offset_t;
  typedef logic [5:0]  bitpos_t;

  localparam opcode_t OP_ALLOC = 2'd0;
  localparam opcode_t OP_FREE  = 2'd1;
  localparam opcode_t OP_CLEAR = 2'd2;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_ZERO  = 2'd1;
  localparam status_t ST_RANGE = 2'd2;
  localparam status_t ST_FULL  = 2'd3;

  localparam count_t COUNT_MAX = 7'd64;

  // Request to the run finder: load a word and a run length.
  typedef struct packed {
    logic   load;
    count_t count;
  } find_req_t;

  // Answer from the run finder, valid in the cycle that done is high.
  typedef struct packed {
    logic    done;
    logic    found;
    bitpos_t pos;
  } find_rsp_t;

  // Mask of n low ones; n is 1 to 64 wherever this is used.
  function automatic logic [WORD_BITS-1:0] run_mask(input count_t n);
    logic [WORD_BITS-1:0] m;
    if (n >= COUNT_MAX) begin
      m = '1;
    end else begin
      m = (64'd1 << n[5:0]) - 64'd1;
    end
    return m;
  endfunction

endpackage

>>> design/tlba_run_finder.sv
`timescale 1ns / 1ps

// Finds the lowest bit position where a run of free slots of the requested
// length begins. One shift-and step per cycle narrows the set of candidate
// starts: after n-1 steps a bit is still set only where n free slots follow.
module tlba_run_finder (
  input  logic                 clk,
  input  logic                 rst,
  input  tlba_pkg::find_req_t  req,
  input  logic [63:0]          word,
  output tlba_pkg::find_rsp_t  rsp
);
  import tlba_pkg::*;

  logic        active;
  logic [63:0] cand;
  logic [5:0]  steps;
  logic        finish;

  function automatic bitpos_t lowest_set(input logic [63:0] v);
    bitpos_t p;
    p = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        p = 6'(i);
      end
    end
    return p;
  endfunction

  assign finish = active && ((steps == 6'd0) || (cand == 64'd0));

  assign rsp.done  = finish;
  assign rsp.found = (cand != 64'd0);
  assign rsp.pos   = lowest_set(cand);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (req.load) begin
      active <= 1'b1;
    end else if (finish) begin
      active <= 1'b0;
    end
  end

  // Zeros shift in from the top, so starts too near the end drop out alone.
  always_ff @(posedge clk) begin
    if (req.load) begin
      cand  <= ~word;
      steps <= 6'(req.count - 7'd1);
    end else if (active && !finish) begin
      cand  <= cand & (cand >> 1);
      steps <= steps - 6'd1;
    end
  end

endmodule

>>> design/two_level_bitmap_allocator_unit.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake           Payload
// in       in         in_valid/in_stall   opcode, slot_count, slot_offset
// out      out        out_valid/out_stall status, granted_offset
//
// Allocate: each word is read in turn from word 0; a word marked full is
// skipped, otherwise the run finder searches it for a run of slot_count.
// Free rewrites one word; clear rewrites every word. Refused or unknown
// requests go straight to the result. Reset starts a clearing pass over the
// word memory; no request is taken until it ends. A request is taken while a
// result waits; a stalled result holds the next one back in its final state.

`include "two_level_bitmap_allocator_unit_macros.svh"

module two_level_bitmap_allocator_unit #(
  parameter int SLOT_TOTAL = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  tlba_pkg::opcode_t   opcode,
  input  tlba_pkg::count_t    slot_count,
  input  tlba_pkg::offset_t   slot_offset,
  output logic                out_valid,
  input  logic                out_stall,
  output tlba_pkg::status_t   status,
  output tlba_pkg::offset_t   granted_offset
);
  import tlba_pkg::*;

  localparam int SLOT_WORDS = SLOT_TOTAL / 64;
  localparam int WORD_W     = (SLOT_WORDS > 1) ? $clog2(SLOT_WORDS) : 1;
  localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(SLOT_WORDS - 1);
  localparam logic [10:0] WORDS_LIMIT = 11'(SLOT_WORDS);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_FIND = 3'd4;
  localparam logic [2:0] S_WR   = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]        state;
  logic [WORD_W-1:0] word;
  logic              sweep_reply;
  opcode_t           op_r;
  count_t            cnt_r;
  bitpos_t           pos_r;
  status_t           status_r;
  offset_t           granted_r;
  logic [63:0]       cur_bits;

  // Each entry holds the full mark above the 64 slot bits of one word.
  logic [64:0]       mem [SLOT_WORDS];
  logic [64:0]       rd_data;
  logic              wr_en;
  logic [64:0]       wr_data;
  logic [63:0]       set_bits;

  find_req_t         find_req;
  find_rsp_t         find_rsp;

  logic              accept;
  logic              out_free;
  logic [7:0]        free_end;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign free_end = {2'b00, slot_offset[5:0]} + {1'b0, slot_count};
  assign set_bits = cur_bits | (run_mask(cnt_r) << pos_r);

  tlba_run_finder u_finder (
    .clk  (clk),
    .rst  (rst),
    .req  (find_req),
    .word (rd_data[63:0]),
    .rsp  (find_rsp)
  );

  always_comb begin
    wr_en          = 1'b0;
    wr_data        = '0;
    find_req.load  = 1'b0;
    find_req.count = cnt_r;
    case (state)
      S_CLR: begin
        wr_en = 1'b1;
      end
      S_CHK: begin
        if (op_r == OP_FREE) begin
          wr_en   = 1'b1;
          wr_data = {1'b0, rd_data[63:0] & ~(run_mask(cnt_r) << pos_r)};
        end else if (!rd_data[64]) begin
          find_req.load = 1'b1;
        end
      end
      S_WR: begin
        wr_en   = 1'b1;
        wr_data = {&set_bits, set_bits};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[word] <= wr_data;
    end
    rd_data <= mem[word];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLR;
      word        <= '0;
      sweep_reply <= 1'b0;
    end else begin
      case (state)
        S_CLR: begin
          if (word == LAST_WORD) begin
            state     <= sweep_reply ? S_DONE : S_IDLE;
            status_r  <= ST_OK;
            granted_r <= '0;
          end else begin
            word <= word + WORD_W'(1);
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_r      <= opcode;
            cnt_r     <= slot_count;
            status_r  <= ST_OK;
            granted_r <= '0;
            case (opcode)
              OP_ALLOC: begin
                if (slot_count == 7'd0) begin
                  status_r <= ST_ZERO;
                  state    <= S_DONE;
                end else if (slot_count > COUNT_MAX) begin
                  status_r <= ST_RANGE;
                  state    <= S_DONE;
                end else begin
                  word  <= '0;
                  state <= S_RD;
                end
              end
              OP_FREE: begin
                if (slot_count == 7'd0) begin
                  status_r <= ST_ZERO;
                  state    <= S_DONE;
                end else if (slot_count > COUNT_MAX || free_end > 8'd64 ||
                             11'(slot_offset[11:6]) >= WORDS_LIMIT) begin
                  status_r <= ST_RANGE;
                  state    <= S_DONE;
                end else begin
                  word  <= WORD_W'(slot_offset[11:6]);
                  pos_r <= slot_offset[5:0];
                  state <= S_RD;
                end
              end
              OP_CLEAR: begin
                word        <= '0;
                sweep_reply <= 1'b1;
                state       <= S_CLR;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_RD: begin
          state <= S_CHK;
        end
        S_CHK: begin
          if (op_r == OP_FREE) begin
            state <= S_DONE;
          end else if (rd_data[64]) begin
            if (word == LAST_WORD) begin
              status_r <= ST_FULL;
              state    <= S_DONE;
            end else begin
              word  <= word + WORD_W'(1);
              state <= S_RD;
            end
          end else begin
            cur_bits <= rd_data[63:0];
            state    <= S_FIND;
          end
        end
        S_FIND: begin
          if (find_rsp.done) begin
            if (find_rsp.found) begin
              pos_r <= find_rsp.pos;
              state <= S_WR;
            end else if (word == LAST_WORD) begin
              status_r <= ST_FULL;
              state    <= S_DONE;
            end else begin
              word  <= word + WORD_W'(1);
              state <= S_RD;
            end
          end
        end
        S_WR: begin
          granted_r <= {6'(word), pos_r};
          state     <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            sweep_reply <= 1'b0;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      status         <= status_r;
      granted_offset <= granted_r;
    end
  end

  // A taken request keeps the input side closed until its result is queued.
  `TLBA_ASSERT_NXT(a_busy_after_accept, clk, rst, accept, in_stall)
  // Only a successful allocation reports a non-zero offset.
  `TLBA_ASSERT_IMP(a_offset_zero_on_fail, clk, rst, out_valid && status != ST_OK, granted_offset == '0)
  // The finder answers only while the sequencer waits for it.
  `TLBA_ASSERT_IMP(a_finder_in_step, clk, rst, find_rsp.done, state == S_FIND)

endmodule

>>> tb/two_level_bitmap_allocator_unit_test.sv
`timescale 1ns / 1ps

module two_level_bitmap_allocator_unit_test;
  import tlba_pkg::*;

  localparam int SLOT_WORDS    = 64;
  localparam int CYCLE_LIMIT   = 8000000;
  localparam int SETTLE_CYCLES = 200;
  localparam int RANDOM_ITEMS  = 400;
  localparam opcode_t OP_NONE  = 2'd3;

  typedef struct {
    opcode_t op;
    count_t  cnt;
    offset_t off;
    bit      drain;
  } request_t;

  typedef struct {
    status_t st;
    offset_t ofs;
  } grant_t;

  logic    clk;
  logic    rst = 1'b1;
  logic    in_valid = 1'b0;
  logic    in_stall;
  opcode_t opcode = OP_NONE;
  count_t  slot_count = '0;
  offset_t slot_offset = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  status_t status;
  offset_t granted_offset;

  logic [63:0] slot_words [SLOT_WORDS];
  logic [63:0] full_words;
  request_t    pending_reqs[$];
  grant_t      awaited_results[$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          idle_left = 0;
  int          stall_left = 0;
  int          random_items = 0;
  bit          in_fire = 1'b0;
  bit          burst_mode = 1'b0;
  bit          stall_mode = 1'b1;

  two_level_bitmap_allocator_unit u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .opcode         (opcode),
    .slot_count     (slot_count),
    .slot_offset    (slot_offset),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .granted_offset (granted_offset)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Applies one request to the shadow bitmaps and works out its answer.
  task automatic update_slot_maps(input opcode_t op, input count_t cnt, input offset_t off,
                                  output grant_t res);
    logic [63:0] m;
    logic [63:0] bits;
    int w;
    int b;
    bit found;
    res.st = ST_OK;
    res.ofs = '0;
    found = 1'b0;
    m = {64{1'b1}} >> (64 - int'(cnt));
    case (op)
      OP_ALLOC: begin
        if (cnt == 0) begin
          res.st = ST_ZERO;
        end else if (cnt > COUNT_MAX) begin
          res.st = ST_RANGE;
        end else begin
          for (w = 0; w < SLOT_WORDS && !found; w++) begin
            if (!full_words[w]) begin
              bits = slot_words[w];
              for (b = 0; b + int'(cnt) <= 64 && !found; b++) begin
                if (((bits >> b) & m) == '0) begin
                  slot_words[w] = bits | (m << b);
                  if (&slot_words[w]) full_words[w] = 1'b1;
                  res.ofs = offset_t'(w * 64 + b);
                  found = 1'b1;
                end
              end
            end
          end
          if (!found) res.st = ST_FULL;
        end
      end
      OP_FREE: begin
        w = int'(off[11:6]);
        b = int'(off[5:0]);
        if (cnt == 0) begin
          res.st = ST_ZERO;
        end else if (cnt > COUNT_MAX || b + int'(cnt) > 64 || w >= SLOT_WORDS) begin
          res.st = ST_RANGE;
        end else begin
          slot_words[w] = slot_words[w] & ~(m << b);
          full_words[w] = 1'b0;
        end
      end
      OP_CLEAR: begin
        for (w = 0; w < SLOT_WORDS; w++) slot_words[w] = '0;
        full_words = '0;
      end
      default: begin
      end
    endcase
  endtask

  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Results are checked before the request of the same edge is booked.
  always @(posedge clk) begin
    grant_t res;
    grant_t want;
    cycle_count++;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: status %0d granted_offset %0d", status, granted_offset);
      end else begin
        want = awaited_results.pop_front();
        if (status !== want.st || granted_offset !== want.ofs) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected status %0d offset %0d, got status %0d offset %0d",
                     want.st, want.ofs, status, granted_offset);
        end
      end
    end
    in_fire = !rst && in_valid && !in_stall;
    if (in_fire) begin
      update_slot_maps(opcode, slot_count, slot_offset, res);
      awaited_results.insert(awaited_results.size(), res);
    end
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(negedge clk) begin
    request_t req;
    if (rst) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (!in_valid || in_fire) begin
        if (idle_left > 0) begin
          in_valid <= 1'b0;
          idle_left--;
        end else if (pending_reqs.size() > 0 &&
                     (!pending_reqs[0].drain || awaited_results.size() == 0)) begin
          req = pending_reqs.pop_front();
          opcode <= req.op;
          slot_count <= req.cnt;
          slot_offset <= req.off;
          in_valid <= 1'b1;
          idle_left = burst_mode ? 0 : pick_pause();
          if ($urandom_range(0, 40) == 0) burst_mode = !burst_mode;
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (stall_mode && $urandom_range(0, 2) == 0) stall_left = pick_pause();
      end
      if ($urandom_range(0, 150) == 0) stall_mode = !stall_mode;
    end
  end

  task automatic push_req(input opcode_t op, input int cnt, input int off, input bit drain);
    request_t req;
    req.op = op;
    req.cnt = count_t'(cnt);
    req.off = offset_t'(off);
    req.drain = drain;
    pending_reqs.insert(pending_reqs.size(), req);
    if (op != OP_NONE) random_items++;
  endtask

  // A run that stays inside one word, at a random place in words 0 to max_word.
  task automatic push_free_run(input int max_word, input int max_cnt);
    int b;
    int c;
    b = $urandom_range(0, 63);
    c = $urandom_range(1, (64 - b) < max_cnt ? (64 - b) : max_cnt);
    push_req(OP_FREE, c, $urandom_range(0, max_word) * 64 + b, 1'b0);
  endtask

  task automatic push_mixed_phase();
    int r;
    int s;
    int c;
    repeat (40) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        s = $urandom_range(0, 9);
        if (s == 0) c = 0;
        else if (s == 1) c = $urandom_range(65, 127);
        else if (s < 4) c = $urandom_range(17, 64);
        else c = $urandom_range(1, 16);
        push_req(OP_ALLOC, c, $urandom_range(0, 4095), 1'b0);
      end else if (r < 95) begin
        if ($urandom_range(0, 4) == 0)
          push_req(OP_FREE, $urandom_range(0, 127), $urandom_range(0, 4095), 1'b0);
        else
          push_free_run(SLOT_WORDS - 1, 64);
      end else if (r < 97) begin
        push_req(OP_CLEAR, $urandom_range(0, 127), $urandom_range(0, 4095), 1'b0);
      end else begin
        push_req(OP_NONE, $urandom_range(0, 127), $urandom_range(0, 4095), 1'b0);
      end
    end
  endtask

  task automatic push_churn_phase();
    repeat (40) begin
      if ($urandom_range(0, 9) < 6)
        push_req(OP_ALLOC, $urandom_range(1, 8), $urandom_range(0, 4095), 1'b0);
      else
        push_free_run(15, 8);
    end
  endtask

  // Clears and fills every word, runs out of space, then reopens a few holes.
  task automatic push_fill_phase();
    push_req(OP_CLEAR, 0, 0, 1'b1);
    repeat (SLOT_WORDS) push_req(OP_ALLOC, 64, $urandom_range(0, 4095), 1'b0);
    repeat (2) push_req(OP_ALLOC, $urandom_range(1, 64), $urandom_range(0, 4095), 1'b0);
    repeat (6) push_free_run(SLOT_WORDS - 1, 64);
    repeat (6) push_req(OP_ALLOC, $urandom_range(1, 16), $urandom_range(0, 4095), 1'b0);
  endtask

  initial begin
    int k;
    for (k = 0; k < SLOT_WORDS; k++) slot_words[k] = '0;
    full_words = '0;

    push_req(OP_ALLOC, 0, 0, 1'b0);
    push_req(OP_ALLOC, 65, 4095, 1'b0);
    push_req(OP_ALLOC, 127, 0, 1'b0);
    push_req(OP_ALLOC, 1, 0, 1'b0);
    push_req(OP_ALLOC, 64, 0, 1'b0);
    push_req(OP_ALLOC, 63, 0, 1'b0);
    push_req(OP_ALLOC, 64, 0, 1'b0);
    push_req(OP_FREE, 0, 0, 1'b0);
    push_req(OP_FREE, 65, 0, 1'b0);
    push_req(OP_FREE, 127, 4095, 1'b0);
    push_req(OP_FREE, 5, 60, 1'b0);
    push_req(OP_FREE, 1, 4095, 1'b0);
    push_req(OP_FREE, 64, 4032, 1'b0);
    push_req(OP_FREE, 64, 64, 1'b0);
    push_req(OP_ALLOC, 64, 0, 1'b0);
    push_req(OP_FREE, 1, 0, 1'b0);
    push_req(OP_ALLOC, 2, 0, 1'b0);
    push_req(OP_ALLOC, 1, 0, 1'b0);
    push_req(OP_NONE, 127, 4095, 1'b0);
    push_req(OP_FREE, 32, 32, 1'b0);
    push_req(OP_CLEAR, 127, 4095, 1'b1);
    push_req(OP_ALLOC, 64, 4095, 1'b0);
    push_req(OP_FREE, 64, 0, 1'b0);

    random_items = 0;
    push_fill_phase();
    while (random_items < RANDOM_ITEMS) begin
      k = $urandom_range(0, 5);
      if (k < 3) push_mixed_phase();
      else if (k < 5) push_churn_phase();
      else push_fill_phase();
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Polled between edges so that the queues are settled.
    do begin
      @(posedge clk);
      #1;
    end while (pending_reqs.size() > 0 || in_valid || awaited_results.size() > 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    #1;

    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
